FILE: src/ordered_list_append_delete_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list append/delete unit
// Each macro wraps one clocked property with an active-low disable iff reset
// guard. The checks compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_APPEND_DELETE_UNIT_DEFINES_SVH
`define ORDERED_LIST_APPEND_DELETE_UNIT_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define OLAD_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> cons) \
    else $error(msg);
// Next-cycle implication.
`define OLAD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> cons) \
    else $error(msg);
`else
`define OLAD_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg)
`define OLAD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

FILE: src/olad_pkg.sv
// ----------------------------------------------------------------------------
// olad_pkg
// Shared types and codes for the ordered list append/delete unit.
// ----------------------------------------------------------------------------
package olad_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VAL_W     = 32;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_DISP = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_SHOWN     = 3'd4
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    append;
    logic    emit;
    status_t emit_status;
    logic    scan_clear;
    logic    rd_issue;
    logic    finish;
  } olad_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_add;
    logic op_del;
    logic op_disp;
    logic empty;
    logic full;
    logic last_issue;
  } olad_sts_t;

endpackage

FILE: src/olad_dp.sv
// ----------------------------------------------------------------------------
// olad_dp
// Datapath: entry memory, count, scan pointers and the result register.
// ----------------------------------------------------------------------------
module olad_dp #(
  parameter int DEPTH = olad_pkg::DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [olad_pkg::OP_W-1:0]            in_op,
  input  logic signed [olad_pkg::VAL_W-1:0]    in_value,
  input  olad_pkg::olad_cmd_t                  cmd,
  output olad_pkg::olad_sts_t                  sts,
  output logic                                 out_strobe,
  output logic signed [olad_pkg::VAL_W-1:0]    out_item_value,
  output logic [olad_pkg::STAT_W-1:0]          out_status,
  output logic                                 out_is_last
);
  import olad_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [VAL_W-1:0]   mem [DEPTH];
  logic [OP_W-1:0]    op_r;
  logic [VAL_W-1:0]   value_r;
  logic [VAL_W-1:0]   rdata_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [AW-1:0]      didx_r;
  logic               rv_r;
  logic               found_r, found_nxt;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [VAL_W-1:0]   mem_wd;
  logic               is_del, match, last_data;
  logic               ostb_nxt, olast_nxt;
  logic [VAL_W-1:0]   oval_nxt;
  logic [STAT_W-1:0]  ostat_nxt;
  logic               ostb_r, olast_r;
  logic [VAL_W-1:0]   oval_r;
  logic [STAT_W-1:0]  ostat_r;

  assign is_del    = (op_r == OP_DEL);
  assign match     = (rdata_r == value_r);
  assign last_data = (CW'(didx_r) == count_r - CW'(1));

  assign sts.op_add     = (op_r == OP_ADD);
  assign sts.op_del     = is_del;
  assign sts.op_disp    = (op_r == OP_DISP);
  assign sts.empty      = (count_r == '0);
  assign sts.full       = (count_r == CW'(DEPTH));
  assign sts.last_issue = (CW'(idx_r) == count_r - CW'(1));

  always_comb begin
    count_nxt = count_r;
    idx_nxt   = idx_r;
    found_nxt = found_r;
    mem_we    = 1'b0;
    mem_wa    = count_r[AW-1:0];
    mem_wd    = value_r;
    ostb_nxt  = 1'b0;
    oval_nxt  = '0;
    ostat_nxt = ST_DONE;
    olast_nxt = 1'b1;

    if (cmd.append) begin
      mem_we    = 1'b1;
      count_nxt = count_r + CW'(1);
    end
    if (cmd.scan_clear) begin
      idx_nxt   = '0;
      found_nxt = 1'b0;
    end
    if (cmd.rd_issue) begin
      idx_nxt = idx_r + AW'(1);
    end
    if (cmd.emit) begin
      ostb_nxt  = 1'b1;
      ostat_nxt = cmd.emit_status;
    end

    // Data read last cycle: compact behind a removed entry, or show it.
    if (rv_r) begin
      if (is_del) begin
        if (found_r) begin
          mem_we = 1'b1;
          mem_wa = didx_r - AW'(1);
          mem_wd = rdata_r;
        end else if (match) begin
          found_nxt = 1'b1;
        end
      end else begin
        ostb_nxt  = 1'b1;
        oval_nxt  = rdata_r;
        ostat_nxt = ST_SHOWN;
        olast_nxt = last_data;
      end
    end

    if (cmd.finish && is_del) begin
      ostb_nxt = 1'b1;
      if (found_r || match) begin
        ostat_nxt = ST_DONE;
        count_nxt = count_r - CW'(1);
      end else begin
        ostat_nxt = ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.rd_issue) begin
      rdata_r <= mem[idx_r];
      didx_r  <= idx_r;
    end
    if (cmd.load) begin
      op_r    <= in_op;
      value_r <= in_value;
    end
    oval_r  <= oval_nxt;
    ostat_r <= ostat_nxt;
    olast_r <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
      rv_r    <= 1'b0;
      found_r <= 1'b0;
      ostb_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      rv_r    <= cmd.rd_issue;
      found_r <= found_nxt;
      ostb_r  <= ostb_nxt;
    end
  end

  assign out_strobe     = ostb_r;
  assign out_item_value = oval_r;
  assign out_status     = ostat_r;
  assign out_is_last    = olast_r;

endmodule

FILE: src/olad_ctrl.sv
// ----------------------------------------------------------------------------
// olad_ctrl
// Controller state machine: decodes a word and sequences the scan.
// ----------------------------------------------------------------------------
module olad_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  olad_pkg::olad_sts_t sts,
  output olad_pkg::olad_cmd_t cmd,
  output logic                busy
);
  import olad_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DEC   = 4'b0010,
    S_READ  = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.emit_status = ST_DONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_IDLE;
        if (sts.op_add) begin
          cmd.emit = 1'b1;
          if (sts.full) begin
            cmd.emit_status = ST_FULL;
          end else begin
            cmd.append      = 1'b1;
            cmd.emit_status = ST_DONE;
          end
        end else if (sts.op_del || sts.op_disp) begin
          if (sts.empty) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_EMPTY;
          end else begin
            cmd.scan_clear = 1'b1;
            state_nxt      = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        if (sts.last_issue) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: src/ordered_list_append_delete_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_append_delete_unit
// Ordered list of signed 32-bit values with append, delete and display.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                   Handshake
//  -------   -------------------------------------   ---------------------------
//  input     in_op, in_value                         start && !busy takes a word
//  result    out_item_value, out_status, out_is_last out_strobe, one cycle each
//
// An add, or any operation on an empty list, is settled in the decode state,
// which then returns to idle. A delete or a display then walks the list in
// the read state and ends in the drain state: the entry memory is read once
// per cycle with registered read data, and a delete compacts the list in the
// same pass by writing each later entry one place lower as it comes back.
// Synchronous reset empties the list; the stored values are not cleared.
// Results leave through a register, one per cycle, and cannot be stalled.
//
module ordered_list_append_delete_unit #(
  parameter int DEPTH = olad_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [olad_pkg::OP_W-1:0]         in_op,
  input  logic signed [olad_pkg::VAL_W-1:0] in_value,
  output logic                              out_strobe,
  output logic signed [olad_pkg::VAL_W-1:0] out_item_value,
  output logic [olad_pkg::STAT_W-1:0]       out_status,
  output logic                              out_is_last
);
  import olad_pkg::*;

`include "ordered_list_append_delete_unit_defines.svh"

  olad_cmd_t cmd;
  olad_sts_t sts;

  // The controller sequences each word; it sees only start and status flags.
  olad_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The datapath holds the entries, the count, the scan pointers and the
  // result register. A delete walks from the head; once the first match is
  // seen, every later entry is written one place lower as it is read.
  olad_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_op          (in_op),
    .in_value       (in_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_strobe     (out_strobe),
    .out_item_value (out_item_value),
    .out_status     (out_status),
    .out_is_last    (out_is_last)
  );

  // An add always answers through the decode state and the result register, as a single result.
  `OLAD_ASSERT_NEXT(a_add_answer, clk, rst_n, start && !busy && in_op == OP_ADD,
    ##1 (out_strobe && out_is_last), "add did not answer with one result")
  // A display streams its entries without gaps until the last one.
  `OLAD_ASSERT_NEXT(a_display_stream, clk, rst_n, out_strobe && !out_is_last,
    out_strobe, "gap in display results")
  // Only shown entries can be followed by more results of the same word.
  `OLAD_ASSERT_IMPLY(a_single_result, clk, rst_n, out_strobe && out_status != ST_SHOWN,
    out_is_last, "non-display result not marked last")

endmodule
